### src/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: cell stack protection package
// Beat types, register codes, reset levels and the per-cell scaling function.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int LANES          = 7;
  localparam int CELL_COUNT     = 7;
  localparam int ADC_BITS       = 12;
  localparam int USED_CELLS     = (CELL_COUNT < LANES) ? CELL_COUNT : LANES;
  localparam int TAP_BITS       = 12;
  localparam int VOLT_BITS      = 12;
  localparam int LEVEL_BITS     = 12;
  localparam int PROD_BITS      = TAP_BITS + LEVEL_BITS;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [TAP_BITS-1:0] ADC_MASK = (ADC_BITS >= TAP_BITS) ?
      {TAP_BITS{1'b1}} : TAP_BITS'((1 << ADC_BITS) - 1);
  localparam logic [VOLT_BITS-1:0] OUT_MAX = {VOLT_BITS{1'b1}};

  localparam logic [CFG_INDEX_BITS-1:0] REG_CHARGE_STOP     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHARGE_RESUME   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISCHARGE_STOP   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISCHARGE_RESUME = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_SCALE       = 3'd4;

  localparam logic [LEVEL_BITS-1:0] CHARGE_STOP_RST      = 12'd420;
  localparam logic [LEVEL_BITS-1:0] CHARGE_RESUME_RST    = 12'd410;
  localparam logic [LEVEL_BITS-1:0] DISCHARGE_STOP_RST   = 12'd300;
  localparam logic [LEVEL_BITS-1:0] DISCHARGE_RESUME_RST = 12'd320;
  localparam logic [LEVEL_BITS-1:0] FULL_SCALE_RST       = 12'd3100;

  typedef struct packed {
    logic [TAP_BITS-1:0] tap_reading_1;
    logic [TAP_BITS-1:0] tap_reading_2;
    logic [TAP_BITS-1:0] tap_reading_3;
    logic [TAP_BITS-1:0] tap_reading_4;
    logic [TAP_BITS-1:0] tap_reading_5;
    logic [TAP_BITS-1:0] tap_reading_6;
    logic [TAP_BITS-1:0] tap_reading_7;
  } tap_set_t;

  typedef struct packed {
    logic [VOLT_BITS-1:0] cell_voltage_1;
    logic [VOLT_BITS-1:0] cell_voltage_2;
    logic [VOLT_BITS-1:0] cell_voltage_3;
    logic [VOLT_BITS-1:0] cell_voltage_4;
    logic [VOLT_BITS-1:0] cell_voltage_5;
    logic [VOLT_BITS-1:0] cell_voltage_6;
    logic [VOLT_BITS-1:0] cell_voltage_7;
    logic                 charge_enable;
    logic                 discharge_enable;
  } result_t;

  // difference clamped at zero, times full_scale, over 2^ADC_BITS, saturated
  function automatic logic [VOLT_BITS-1:0] scale_cell(
      input logic [TAP_BITS-1:0]   upper,
      input logic [TAP_BITS-1:0]   lower,
      input logic [LEVEL_BITS-1:0] full_scale);
    logic [TAP_BITS-1:0]  diff;
    logic [PROD_BITS-1:0] prod;
    logic [PROD_BITS-1:0] shifted;
    diff    = (upper > lower) ? (upper - lower) : '0;
    prod    = PROD_BITS'(diff) * PROD_BITS'(full_scale);
    shifted = prod >> ADC_BITS;
    return (shifted > PROD_BITS'(OUT_MAX)) ? OUT_MAX : shifted[VOLT_BITS-1:0];
  endfunction

endpackage

### src/cell_stack_protection_top.sv
// ----------------------------------------------------------------------------
// cell_stack_protection_top: seven-cell over/under voltage protection
// Scales stack-tap differences to cell voltages and keeps charge and
// discharge enables with hysteresis.
// ----------------------------------------------------------------------------
// Takes one tap beat per cycle unless a stalled result backs up into the input
// register. A tap beat passes through the input register, then the result register,
// to the port; between those two registers lie one subtract, 12x12 multiply,
// saturate and compare per lane plus the two flag updates. A stalled result
// holds while one more tap beat waits in the input register. cfg_ready is
// always high; write registers only while no beat is in flight.
module cell_stack_protection_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                tap_valid,
  output logic                                tap_ready,
  input  csp_pkg::tap_set_t                   taps,
  output logic                                result_valid,
  input  logic                                result_ready,
  output csp_pkg::result_t                    result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [csp_pkg::LEVEL_BITS-1:0]      cfg_data
);
  import csp_pkg::*;

  logic [LEVEL_BITS-1:0] charge_stop_level;
  logic [LEVEL_BITS-1:0] charge_resume_level;
  logic [LEVEL_BITS-1:0] discharge_stop_level;
  logic [LEVEL_BITS-1:0] discharge_resume_level;
  logic [LEVEL_BITS-1:0] full_scale;
  logic                  charge_on;
  logic                  discharge_on;
  logic                  stage_valid;
  tap_set_t              stage_taps;

  logic                  advance;
  logic [TAP_BITS-1:0]   tap [LANES];
  logic [VOLT_BITS-1:0]  volt [LANES];
  logic                  any_high, all_low_ok, any_low, all_high_ok;
  logic                  charge_next, discharge_next;
  result_t               result_next;

  assign cfg_ready = 1'b1;
  assign advance   = !result_valid || result_ready;
  assign tap_ready = !stage_valid || advance;

  always_comb begin
    tap[0] = stage_taps.tap_reading_1 & ADC_MASK;
    tap[1] = stage_taps.tap_reading_2 & ADC_MASK;
    tap[2] = stage_taps.tap_reading_3 & ADC_MASK;
    tap[3] = stage_taps.tap_reading_4 & ADC_MASK;
    tap[4] = stage_taps.tap_reading_5 & ADC_MASK;
    tap[5] = stage_taps.tap_reading_6 & ADC_MASK;
    tap[6] = stage_taps.tap_reading_7 & ADC_MASK;
  end

  always_comb begin
    any_high    = 1'b0;
    all_low_ok  = 1'b1;
    any_low     = 1'b0;
    all_high_ok = 1'b1;
    for (int i = 0; i < LANES; i++) begin
      volt[i] = '0;
      if (i < USED_CELLS) begin
        volt[i] = scale_cell(tap[i], (i == 0) ? '0 : tap[(i == 0) ? 0 : i - 1],
                             full_scale);
        if (volt[i] > charge_stop_level)      any_high    = 1'b1;
        if (volt[i] > charge_resume_level)    all_low_ok  = 1'b0;
        if (volt[i] < discharge_stop_level)   any_low     = 1'b1;
        if (volt[i] < discharge_resume_level) all_high_ok = 1'b0;
      end
    end
  end

  // resume wins over stop
  always_comb begin
    priority if (all_low_ok) begin
      charge_next = 1'b1;
    end else if (any_high) begin
      charge_next = 1'b0;
    end else begin
      charge_next = charge_on;
    end
    priority if (all_high_ok) begin
      discharge_next = 1'b1;
    end else if (any_low) begin
      discharge_next = 1'b0;
    end else begin
      discharge_next = discharge_on;
    end
  end

  always_comb begin
    result_next.cell_voltage_1   = volt[0];
    result_next.cell_voltage_2   = volt[1];
    result_next.cell_voltage_3   = volt[2];
    result_next.cell_voltage_4   = volt[3];
    result_next.cell_voltage_5   = volt[4];
    result_next.cell_voltage_6   = volt[5];
    result_next.cell_voltage_7   = volt[6];
    result_next.charge_enable    = charge_next;
    result_next.discharge_enable = discharge_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_stop_level      <= CHARGE_STOP_RST;
      charge_resume_level    <= CHARGE_RESUME_RST;
      discharge_stop_level   <= DISCHARGE_STOP_RST;
      discharge_resume_level <= DISCHARGE_RESUME_RST;
      full_scale             <= FULL_SCALE_RST;
      charge_on              <= 1'b0;
      discharge_on           <= 1'b0;
      stage_valid            <= 1'b0;
      result_valid           <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CHARGE_STOP:      charge_stop_level      <= cfg_data;
          REG_CHARGE_RESUME:    charge_resume_level    <= cfg_data;
          REG_DISCHARGE_STOP:   discharge_stop_level   <= cfg_data;
          REG_DISCHARGE_RESUME: discharge_resume_level <= cfg_data;
          REG_FULL_SCALE:       full_scale             <= cfg_data;
          default: ;
        endcase
      end
      if (tap_ready) begin
        stage_valid <= tap_valid;
      end
      if (advance) begin
        result_valid <= stage_valid;
        if (stage_valid) begin
          charge_on    <= charge_next;
          discharge_on <= discharge_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tap_ready && tap_valid) begin
      stage_taps <= taps;
    end
    if (advance && stage_valid) begin
      result <= result_next;
    end
  end

endmodule

### src/csp_checker.sv
// ----------------------------------------------------------------------------
// csp_checker: port-level checks for cell_stack_protection_top
// Tracks register writes and checks handshake and hysteresis on result beats.
// ----------------------------------------------------------------------------
module csp_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                result_valid,
  input logic                                result_ready,
  input csp_pkg::result_t                    result,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [csp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input logic [csp_pkg::LEVEL_BITS-1:0]      cfg_data
);
  import csp_pkg::*;

  logic [LEVEL_BITS-1:0] charge_stop;
  logic [LEVEL_BITS-1:0] charge_resume;
  logic [LEVEL_BITS-1:0] discharge_resume;
  logic [VOLT_BITS-1:0]  cells [LANES];
  logic                  all_low, all_high, any_over, some_above_resume;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_stop      <= CHARGE_STOP_RST;
      charge_resume    <= CHARGE_RESUME_RST;
      discharge_resume <= DISCHARGE_RESUME_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CHARGE_STOP)      charge_stop      <= cfg_data;
      if (cfg_index == REG_CHARGE_RESUME)    charge_resume    <= cfg_data;
      if (cfg_index == REG_DISCHARGE_RESUME) discharge_resume <= cfg_data;
    end
  end

  always_comb begin
    cells[0] = result.cell_voltage_1;
    cells[1] = result.cell_voltage_2;
    cells[2] = result.cell_voltage_3;
    cells[3] = result.cell_voltage_4;
    cells[4] = result.cell_voltage_5;
    cells[5] = result.cell_voltage_6;
    cells[6] = result.cell_voltage_7;
    all_low           = 1'b1;
    all_high          = 1'b1;
    any_over          = 1'b0;
    some_above_resume = 1'b0;
    for (int i = 0; i < USED_CELLS; i++) begin
      if (cells[i] > charge_resume)    all_low           = 1'b0;
      if (cells[i] > charge_resume)    some_above_resume = 1'b1;
      if (cells[i] < discharge_resume) all_high          = 1'b0;
      if (cells[i] > charge_stop)      any_over          = 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_charge_resume: assert property (@(posedge clk) disable iff (rst)
    result_valid && all_low |-> result.charge_enable)
    else $error("charge off with all cells at or below resume level");

  a_charge_stop: assert property (@(posedge clk) disable iff (rst)
    result_valid && any_over && some_above_resume |-> !result.charge_enable)
    else $error("charge on with a cell above stop level");

  a_discharge_resume: assert property (@(posedge clk) disable iff (rst)
    result_valid && all_high |-> result.discharge_enable)
    else $error("discharge off with all cells at or above resume level");

endmodule

bind cell_stack_protection_top csp_checker u_csp_checker (.*);
